// ===== rtl/lz77td_pkg.sv =====
package lz77td_pkg;

   // History window.
   localparam int unsigned HIST_DEPTH = 4096;
   localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

   // Output packing.
   localparam int unsigned BYTES_PER_WORD = 8;
   localparam int unsigned BYTE_IDX_W     = $clog2(BYTES_PER_WORD);
   localparam int unsigned COUNT_W        = 4;
   localparam int unsigned GRP_W          = $clog2(BYTES_PER_WORD + 1);

   // Token fields.
   localparam int unsigned LIT_W      = 8;
   localparam int unsigned DIST_W     = 12;
   localparam int unsigned LEN_W      = 8;
   localparam int unsigned LEN_BIAS   = 3;
   localparam int unsigned REMAIN_W   = LEN_W + 1;

   // Packed stream widths.
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 72;

   typedef logic [7:0] byte_type;

   typedef enum logic {
      KIND_LITERAL = 1'b0,
      KIND_MATCH   = 1'b1
   } kind_type;

endpackage

// ===== rtl/lz77_token_decompressor_core.sv =====
// LZSS token decoder with a 4096-byte circular history held in one
// single-port-write, registered-read memory. After a literal token, the next
// token is taken once the literal's word has moved to the output register. A
// match of L bytes (L = length_code + 3, up to 258) reads the history one
// byte per cycle through the single read port, pausing while a full word
// waits to move to the output register, which a held-back output prolongs.
// Bytes leave in words of up to eight, and the last word of a
// token carries tlast. Overlapping copies are served by forwarding the byte
// being written into the read that hits it. History entries not yet written
// since reset read as zero, tracked by the write position and a wrap flag,
// so no clearing pass follows reset.
module lz77_token_decompressor_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata from bit 0: literal_byte[7:0], distance_code[11:0],
   // length_code[7:0], zero fill.
   input  logic [lz77td_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: func (0 literal, 1 match).
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata from bit 0: byte_0 .. byte_7 (8 bits each), byte_count[3:0],
   // zero fill.
   output logic [lz77td_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tlast: last_of_token.
   output logic                               rsp_tlast
);

   import lz77td_pkg::*;

   // History memory.
   byte_type            hist_mem [HIST_DEPTH];
   byte_type            mem_q_ff;

   // Token fields.
   byte_type            lit_byte;
   logic [DIST_W-1:0]   dist_code;
   logic [LEN_W-1:0]    len_code;
   logic                lit_acc;
   logic                match_acc;

   // Control registers.
   logic [HIST_AW-1:0]  wr_pos_ff, wr_pos_in;
   logic                wrapped_ff, wrapped_in;
   logic [HIST_AW-1:0]  rd_addr_ff, rd_addr_in;
   logic [REMAIN_W-1:0] remain_ff, remain_in;
   logic [GRP_W-1:0]    grp_issued_ff, grp_issued_in;
   logic [GRP_W-1:0]    acc_cnt_ff, acc_cnt_in;
   logic                pend_ff, pend_in;
   logic                fwd_hit_ff, fwd_hit_in;
   byte_type            fwd_data_ff, fwd_data_in;
   logic                written_ff, written_in;

   // Word assembly and output register.
   byte_type            acc_ff [BYTES_PER_WORD];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   // Datapath signals.
   logic                issue;
   logic                acc_full;
   logic                out_free;
   logic                move;
   logic                wr_en;
   byte_type            wr_data;
   byte_type            land_byte;

   // Unpack the request word.
   assign lit_byte  = req_tdata[LIT_W-1:0];
   assign dist_code = req_tdata[LIT_W +: DIST_W];
   assign len_code  = req_tdata[LIT_W + DIST_W +: LEN_W];

   assign req_tready = !pend_ff && (grp_issued_ff == '0) && (remain_ff == '0);
   assign lit_acc    = req_tvalid && req_tready && (req_tuser == KIND_LITERAL);
   assign match_acc  = req_tvalid && req_tready && (req_tuser == KIND_MATCH);

   // A landing byte comes from the forward path, the memory, or reads as zero.
   assign land_byte = fwd_hit_ff ? fwd_data_ff : (written_ff ? mem_q_ff : '0);

   // A word is complete once all its issued reads have landed.
   assign acc_full = !pend_ff && (grp_issued_ff != '0)
                     && ((grp_issued_ff == GRP_W'(BYTES_PER_WORD)) || (remain_ff == '0));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign move     = acc_full && out_free;
   assign issue    = (remain_ff != '0)
                     && ((grp_issued_ff != GRP_W'(BYTES_PER_WORD)) || move);

   // One history write a cycle: a literal, or a copied byte as it lands.
   assign wr_en   = lit_acc || pend_ff;
   assign wr_data = pend_ff ? land_byte : lit_byte;

   always_comb begin
      wr_pos_in     = wr_pos_ff;
      wrapped_in    = wrapped_ff;
      rd_addr_in    = rd_addr_ff;
      remain_in     = remain_ff;
      grp_issued_in = grp_issued_ff;
      acc_cnt_in    = acc_cnt_ff;
      pend_in       = issue;
      fwd_hit_in    = pend_ff && (rd_addr_ff == wr_pos_ff);
      fwd_data_in   = land_byte;
      written_in    = wrapped_ff || (rd_addr_ff < wr_pos_ff);

      // Write position advances with every byte put into the history.
      if (wr_en) begin
         wr_pos_in = wr_pos_ff + 1'b1;
         if (wr_pos_ff == HIST_AW'(HIST_DEPTH - 1)) begin
            wrapped_in = 1'b1;
         end
      end

      // Start a match at the source position behind the write position.
      if (match_acc) begin
         rd_addr_in = wr_pos_ff - HIST_AW'(dist_code) - 1'b1;
         remain_in  = REMAIN_W'(len_code) + REMAIN_W'(LEN_BIAS);
      end else if (issue) begin
         rd_addr_in = rd_addr_ff + 1'b1;
         remain_in  = remain_ff - 1'b1;
      end

      // Count reads issued into the current word.
      if (lit_acc) begin
         grp_issued_in = GRP_W'(1);
      end else if (move && issue) begin
         grp_issued_in = GRP_W'(1);
      end else if (move) begin
         grp_issued_in = '0;
      end else if (issue) begin
         grp_issued_in = grp_issued_ff + 1'b1;
      end

      // Count bytes landed in the current word.
      if (lit_acc) begin
         acc_cnt_in = GRP_W'(1);
      end else if (move) begin
         acc_cnt_in = '0;
      end else if (pend_ff) begin
         acc_cnt_in = acc_cnt_ff + 1'b1;
      end
   end

   // Output word, with bytes beyond the count forced to zero.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         for (int k = 0; k < BYTES_PER_WORD; k++) begin
            if (GRP_W'(k) < grp_issued_ff) begin
               rsp_data_in[8*k +: 8] = acc_ff[k];
            end
         end
         rsp_data_in[8*BYTES_PER_WORD +: COUNT_W] = COUNT_W'(grp_issued_ff);
         rsp_last_in  = (remain_ff == '0);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff     <= '0;
         wrapped_ff    <= 1'b0;
         remain_ff     <= '0;
         grp_issued_ff <= '0;
         acc_cnt_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wr_pos_ff     <= wr_pos_in;
         wrapped_ff    <= wrapped_in;
         remain_ff     <= remain_in;
         grp_issued_ff <= grp_issued_in;
         acc_cnt_ff    <= acc_cnt_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_data_ff <= fwd_data_in;
      written_ff  <= written_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (lit_acc) begin
         acc_ff[0] <= lit_byte;
      end else if (pend_ff) begin
         acc_ff[acc_cnt_ff[BYTE_IDX_W-1:0]] <= land_byte;
      end
   end

   // History memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_pos_ff] <= wr_data;
      end
      mem_q_ff <= hist_mem[rd_addr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // A word never holds more bytes than it can carry.
   a_grp_bound: assert property (@(posedge clock) disable iff (reset)
      grp_issued_ff <= GRP_W'(BYTES_PER_WORD))
      else $error("word assembly overfilled");

   // A landing byte always has a free slot that was issued for it.
   a_land_slot: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (acc_cnt_ff < grp_issued_ff))
      else $error("byte landed without an issued slot");

   // A new token is taken only when no copy is in flight.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!pend_ff && (remain_ff == '0)))
      else $error("token accepted while busy");

   // Every word sent carries at least one byte.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[8*BYTES_PER_WORD +: COUNT_W] != '0))
      else $error("empty output word");
`endif

endmodule
